FILE: src/lane_slope_steering_assert.svh
// assertion macros shared by the lane slope steering rtl
`ifndef LANE_SLOPE_STEERING_ASSERT_SVH
`define LANE_SLOPE_STEERING_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define LSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define LSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: src/lss_pkg.sv
`timescale 1ns / 1ps
package lss_pkg;

  // parameter defaults
  localparam int COORD_BITS_DEF = 10;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 8;

  // fixed field widths
  localparam int ROW_W   = 10;
  localparam int THR_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MEAN_W  = 19;
  localparam int DIR_W   = 2;
  localparam int COUNT_W = 11;

  // threshold is given in q8.8
  localparam int THR_FRAC = 8;

  // register reset values
  localparam logic [ROW_W-1:0] ROW_UPPER_RST = 10'd50;
  localparam logic [ROW_W-1:0] ROW_LOWER_RST = 10'd70;
  localparam logic [THR_W-1:0] THR_RST       = 16'd51;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_THR  = 2'd2;

  typedef enum logic [DIR_W-1:0] {
    DIR_STRAIGHT = 2'd0,
    DIR_LEFT     = 2'd1,
    DIR_RIGHT    = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOPE,
    ST_MEAN_GO,
    ST_MEAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/lss_ifs.sv
`timescale 1ns / 1ps
interface lss_in_if #(
  parameter int COORD_BITS = lss_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  has_point;
  logic                  frame_last;

  modport source (output valid, point_x, point_y, has_point, frame_last, input ready);
  modport sink   (input valid, point_x, point_y, has_point, frame_last, output ready);
endinterface

interface lss_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lss_pkg::MEAN_W-1:0]   mean_slope;
  logic        [lss_pkg::DIR_W-1:0]    direction;
  logic        [lss_pkg::COUNT_W-1:0]  slope_count;
  logic                                zero_step_seen;

  modport source (output valid, mean_slope, direction, slope_count, zero_step_seen,
                  input ready);
  modport sink   (input valid, mean_slope, direction, slope_count, zero_step_seen,
                  output ready);
endinterface

FILE: src/lss_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, dividend left aligned
module lss_div #(
  parameter int DIV_W  = 29,
  parameter int DVS_W  = 11,
  parameter int STEP_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [DVS_W-1:0]   divisor,
  input  logic [STEP_W-1:0]  steps,
  output logic [DIV_W-1:0]   quotient,
  output lss_pkg::div_stat_t stat
);

  logic [DIV_W-1:0]  q_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  d_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic              fits;
  logic [DVS_W-1:0]  rem_nxt;
  logic [DIV_W-1:0]  q_nxt;

  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d_r};
  assign fits    = ~diff[DVS_W+1];
  assign rem_nxt = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  assign q_nxt   = {q_r[DIV_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: src/lane_slope_steering.sv
`timescale 1ns / 1ps
// lane slope steering
// in_bus carries one lane midpoint per word (point_x, point_y, has_point,
// frame_last); a point counts only when its row is strictly between row_upper
// and row_lower. each counted point after the first of a frame adds dx/dy
// (signed, FRAC_BITS fraction bits, truncated toward zero) to a running sum.
// the word with frame_last set yields one out_bus word: mean slope, direction
// (straight, left, right against +/-turn_threshold), slope count and a flag
// for skipped segments with equal rows. other words yield nothing.
// cfg_we/cfg_idx/cfg_wdata write row_upper (0), row_lower (1), turn_threshold
// (2, q8.8); the user must do so only while the block is idle (not enforced).
// one word is worked on at a time, all through one bit-serial divider.
// a slope takes COORD_BITS+FRAC_BITS divider steps; a frame with slopes adds
// COORD_BITS+FRAC_BITS+clog2(MAX_POINTS+1) steps for the mean at frame end.
// the result sits in an output register, so in_bus takes new words while it
// waits; a stalled receiver only holds the block at the next frame end.
// reset (synchronous, rst_n low) restores register defaults 50/70/51 and
// clears the frame state but for mean_r and neg_r; no clearing pass is needed.
module lane_slope_steering #(
  parameter int COORD_BITS = lss_pkg::COORD_BITS_DEF,
  parameter int MAX_POINTS = lss_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = lss_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lss_in_if.sink                        in_bus,
  lss_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [lss_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lss_pkg::CFG_W-1:0]     cfg_wdata
);

  `include "lane_slope_steering_assert.svh"

  localparam int CB      = COORD_BITS;
  localparam int TALLY_W = $clog2(MAX_POINTS + 1);
  localparam int NUM_W   = CB + FRAC_BITS;
  localparam int DIV_W   = NUM_W + TALLY_W;
  localparam int SUM_W   = DIV_W + 1;
  localparam int DVS_W   = (CB > TALLY_W) ? CB : TALLY_W;
  localparam int STEP_W  = $clog2(DIV_W + 1);
  localparam int ROW_W   = lss_pkg::ROW_W;
  localparam int RCMP_W  = (CB > ROW_W) ? CB : ROW_W;
  localparam int TW      = lss_pkg::THR_W;
  localparam int THR_W   = TW + FRAC_BITS;
  localparam int CMP_W   = ((SUM_W > THR_W) ? SUM_W : THR_W) + 1;
  localparam int MEAN_OW = lss_pkg::MEAN_W;
  localparam int CNT_OW  = lss_pkg::COUNT_W;

  // configuration
  logic [ROW_W-1:0] row_upper_r;
  logic [ROW_W-1:0] row_lower_r;
  logic [TW-1:0]    thr_r;

  // frame state
  lss_pkg::state_t     state_r, state_nxt;
  logic [CB-1:0]       prev_col_r;
  logic [CB-1:0]       prev_row_r;
  logic                have_prev_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [TALLY_W-1:0]  tally_r;
  logic                zero_flag_r;
  logic                last_r;
  logic                neg_r;
  logic signed [SUM_W-1:0] mean_r;

  // output register
  logic                       out_valid_r;
  logic signed [MEAN_OW-1:0]  out_mean_r;
  logic [lss_pkg::DIR_W-1:0]  out_dir_r;
  logic [CNT_OW-1:0]          out_cnt_r;
  logic                       out_zero_r;

  // control from the sequencer
  logic in_ready;
  logic div_start;
  logic sel_mean;
  logic out_load;
  logic in_fire;
  logic out_free;

  // point qualification
  logic [RCMP_W-1:0] y_ext, up_ext, lo_ext;
  logic              in_win;
  logic [CB:0]       dx_u, dy_u, dx_abs, dy_abs;
  logic              dy_zero;
  logic              tally_room;
  logic              take_slope;
  logic              seg_zero;
  logic              tally_zero;

  // divider hookup
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic [STEP_W-1:0]  div_steps;
  logic [DIV_W-1:0]   div_q;
  lss_pkg::div_stat_t div_stat;
  logic [SUM_W-1:0]   sum_abs;
  logic signed [SUM_W-1:0] q_signed;

  // direction decision
  logic [THR_W-1:0]        thr_val;
  logic signed [CMP_W-1:0] mean_ext, thr_ext;
  lss_pkg::dir_t           dir_nxt;

  assign in_fire  = in_bus.valid & in_ready;
  assign out_free = ~out_valid_r | out_bus.ready;

  assign y_ext   = RCMP_W'(in_bus.point_y);
  assign up_ext  = RCMP_W'(row_upper_r);
  assign lo_ext  = RCMP_W'(row_lower_r);
  assign in_win  = in_bus.has_point & (y_ext > up_ext) & (y_ext < lo_ext);

  assign dx_u    = {1'b0, in_bus.point_x} - {1'b0, prev_col_r};
  assign dy_u    = {1'b0, in_bus.point_y} - {1'b0, prev_row_r};
  assign dx_abs  = dx_u[CB] ? (~dx_u + (CB+1)'(1)) : dx_u;
  assign dy_abs  = dy_u[CB] ? (~dy_u + (CB+1)'(1)) : dy_u;
  assign dy_zero = (in_bus.point_y == prev_row_r);

  assign tally_room = (tally_r < TALLY_W'(MAX_POINTS));
  assign tally_zero = (tally_r == '0);
  assign take_slope = in_win & have_prev_r & ~dy_zero & tally_room;
  assign seg_zero   = in_win & have_prev_r & dy_zero;

  // magnitude of the sum for the mean division
  assign sum_abs = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  // slope dividend is |dx| scaled by the fraction bits, top aligned
  always_comb begin
    if (sel_mean) begin
      div_dividend = sum_abs[DIV_W-1:0];
      div_divisor  = DVS_W'(tally_r);
      div_steps    = STEP_W'(DIV_W);
    end else begin
      div_dividend = {dx_abs[CB-1:0], {FRAC_BITS{1'b0}}, {TALLY_W{1'b0}}};
      div_divisor  = DVS_W'(dy_abs[CB-1:0]);
      div_steps    = STEP_W'(NUM_W);
    end
  end

  lss_div #(
    .DIV_W  (DIV_W),
    .DVS_W  (DVS_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // quotient with its sign applied, truncation toward zero
  assign q_signed = neg_r ? -$signed(SUM_W'(div_q)) : $signed(SUM_W'(div_q));
  assign sum_nxt  = sum_r + q_signed;

  // threshold rescaled from q8.8, dropped bits truncated
  assign thr_val  = {thr_r, {FRAC_BITS{1'b0}}} >> lss_pkg::THR_FRAC;
  assign mean_ext = CMP_W'(mean_r);
  assign thr_ext  = $signed(CMP_W'(thr_val));

  always_comb begin
    if (mean_ext <= -thr_ext) begin
      dir_nxt = lss_pkg::DIR_RIGHT;
    end else if (mean_ext >= thr_ext) begin
      dir_nxt = lss_pkg::DIR_LEFT;
    end else begin
      dir_nxt = lss_pkg::DIR_STRAIGHT;
    end
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lss_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (take_slope) begin
            state_nxt = lss_pkg::ST_SLOPE;
          end else if (in_bus.frame_last) begin
            state_nxt = lss_pkg::ST_MEAN_GO;
          end
        end
      end
      lss_pkg::ST_SLOPE: begin
        if (div_stat.done) begin
          state_nxt = last_r ? lss_pkg::ST_MEAN_GO : lss_pkg::ST_IDLE;
        end
      end
      lss_pkg::ST_MEAN_GO: begin
        state_nxt = tally_zero ? lss_pkg::ST_FIN : lss_pkg::ST_MEAN;
      end
      lss_pkg::ST_MEAN: begin
        if (div_stat.done) begin
          state_nxt = lss_pkg::ST_FIN;
        end
      end
      lss_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = lss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lss_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    sel_mean  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      lss_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_bus.valid & take_slope;
      end
      lss_pkg::ST_MEAN_GO: begin
        sel_mean  = 1'b1;
        div_start = ~tally_zero;
      end
      lss_pkg::ST_FIN: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_bus.ready = in_ready;

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lss_pkg::ST_IDLE;
      row_upper_r <= lss_pkg::ROW_UPPER_RST;
      row_lower_r <= lss_pkg::ROW_LOWER_RST;
      thr_r       <= lss_pkg::THR_RST;
      prev_col_r  <= '0;
      prev_row_r  <= '0;
      have_prev_r <= 1'b0;
      sum_r       <= '0;
      tally_r     <= '0;
      zero_flag_r <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_idx)
          lss_pkg::CFG_ROW_UPPER: row_upper_r <= cfg_wdata[ROW_W-1:0];
          lss_pkg::CFG_ROW_LOWER: row_lower_r <= cfg_wdata[ROW_W-1:0];
          lss_pkg::CFG_TURN_THR:  thr_r       <= cfg_wdata[TW-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        last_r <= in_bus.frame_last;
        if (in_win) begin
          prev_col_r  <= in_bus.point_x;
          prev_row_r  <= in_bus.point_y;
          have_prev_r <= 1'b1;
        end
        if (seg_zero) begin
          zero_flag_r <= 1'b1;
        end
      end

      if ((state_r == lss_pkg::ST_SLOPE) && div_stat.done) begin
        sum_r   <= sum_nxt;
        tally_r <= tally_r + TALLY_W'(1);
      end

      // frame end: result handed over, frame state cleared
      if (out_load) begin
        have_prev_r <= 1'b0;
        sum_r       <= '0;
        tally_r     <= '0;
        zero_flag_r <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= sel_mean ? sum_r[SUM_W-1] : (dx_u[CB] ^ dy_u[CB]);
    end
    if ((state_r == lss_pkg::ST_MEAN_GO) && tally_zero) begin
      mean_r <= '0;
    end else if ((state_r == lss_pkg::ST_MEAN) && div_stat.done) begin
      mean_r <= q_signed;
    end
    if (out_load) begin
      out_mean_r <= MEAN_OW'(mean_r);
      out_dir_r  <= dir_nxt;
      out_cnt_r  <= CNT_OW'(tally_r);
      out_zero_r <= zero_flag_r;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.mean_slope     = out_mean_r;
  assign out_bus.direction      = out_dir_r;
  assign out_bus.slope_count    = out_cnt_r;
  assign out_bus.zero_step_seen = out_zero_r;

  // no new word while a division is running
  `LSS_ASSERT(a_ready_div_idle, clk, rst_n, in_ready |-> !div_stat.busy, "word taken during division")
  // divider finishes only in a state that consumes its result
  `LSS_ASSERT(a_done_state, clk, rst_n, div_stat.done |-> (state_r == lss_pkg::ST_SLOPE || state_r == lss_pkg::ST_MEAN), "divider result dropped")
  // slope count stays within its limit
  `LSS_ASSERT(a_tally_max, clk, rst_n, tally_r <= TALLY_W'(MAX_POINTS), "slope count past limit")
  // handing over a result clears the frame
  `LSS_ASSERT(a_frame_clear, clk, rst_n, out_load |=> (tally_r == '0 && !have_prev_r && !zero_flag_r), "frame state not cleared")

endmodule
